// ----- rtl/ols_pkg.sv -----
package ols_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int POS_W      = 6;
	localparam int CMP_W      = (CNT_W + 1 > POS_W + 1) ? CNT_W + 1 : POS_W + 1;

	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_INS_POS   = 3'd2;
	localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
	localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
	localparam logic [2:0] REQ_DEL_POS   = 3'd5;
	localparam logic [2:0] REQ_DUMP_FWD  = 3'd6;
	localparam logic [2:0] REQ_DUMP_BACK = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_DELETE = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [IDX_W-1:0]      at;
		logic [DATA_WIDTH-1:0] data;
		logic [IDX_W-1:0]      sel;
	} cell_ctl_t;

	function automatic logic [DATA_WIDTH-1:0] in_value(logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] out_value(logic [DATA_WIDTH-1:0] v);
		logic signed [63:0] w;
		w = 64'($signed(v));
		return w[31:0];
	endfunction

endpackage

// ----- rtl/ols_cell.sv -----
module ols_cell
	import ols_pkg::*;
(
	input  logic                  clk,
	input  logic [IDX_W-1:0]      idx,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] q,
	output logic [DATA_WIDTH-1:0] rd_part
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (idx > ctl.at) begin
					data_q <= left;
				end else if (idx == ctl.at) begin
					data_q <= ctl.data;
				end
			end
			CELL_DELETE: begin
				if (idx >= ctl.at) begin
					data_q <= right;
				end
			end
			default: ;
		endcase
	end

	assign q       = data_q;
	assign rd_part = (idx == ctl.sel) ? data_q : '0;

endmodule

// ----- rtl/ols_ctrl.sv -----
module ols_ctrl
	import ols_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic [DATA_WIDTH-1:0] rd_data,
	output cell_ctl_t             ctl
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_DUMP = 1'b1;

	logic [0:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic             bwd_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [CMP_W-1:0] cnt_w, pos_w, p;
	logic             ins, del, dmp, bwd;
	logic             full, empty, in_rng_ins, in_rng_del;
	logic             accept, out_free, dump_last;
	logic [CNT_W-1:0] ptr;

	assign cnt_w    = CMP_W'(count_q);
	assign pos_w    = CMP_W'(req.position);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q == S_DUMP) || !out_free;
	assign accept   = req_valid && !req_stall;

	always_comb begin
		p   = pos_w;
		ins = 1'b0;
		del = 1'b0;
		dmp = 1'b0;
		bwd = 1'b0;
		case (req.req_type)
			REQ_INS_FRONT: begin
				p   = CMP_W'(1);
				ins = 1'b1;
			end
			REQ_INS_BACK: begin
				p   = cnt_w + CMP_W'(1);
				ins = 1'b1;
			end
			REQ_INS_POS: ins = 1'b1;
			REQ_DEL_FRONT: begin
				p   = CMP_W'(1);
				del = 1'b1;
			end
			REQ_DEL_BACK: begin
				p   = cnt_w;
				del = 1'b1;
			end
			REQ_DEL_POS: del = 1'b1;
			REQ_DUMP_FWD: dmp = 1'b1;
			default: begin
				dmp = 1'b1;
				bwd = 1'b1;
			end
		endcase
	end

	assign in_rng_ins = (p != '0) && (p <= cnt_w + CMP_W'(1));
	assign in_rng_del = (p != '0) && (p <= cnt_w);

	assign ptr       = bwd_q ? (count_q - CNT_W'(1) - k_q) : k_q;
	assign dump_last = (k_q == count_q - CNT_W'(1));

	always_comb begin
		ctl.op   = CELL_HOLD;
		ctl.at   = IDX_W'(p - CMP_W'(1));
		ctl.data = in_value(req.value);
		ctl.sel  = (state_q == S_DUMP) ? IDX_W'(ptr) : IDX_W'(p - CMP_W'(1));
		if (accept && ins && !full && in_rng_ins) begin
			ctl.op = CELL_INSERT;
		end else if (accept && del && !empty && in_rng_del) begin
			ctl.op = CELL_DELETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			bwd_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (dmp && !empty) begin
							state_q <= S_DUMP;
							k_q     <= '0;
							bwd_q   <= bwd;
						end else begin
							rsp_valid_q <= 1'b1;
						end
						if (ctl.op == CELL_INSERT) begin
							count_q <= count_q + CNT_W'(1);
						end else if (ctl.op == CELL_DELETE) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						k_q         <= k_q + CNT_W'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DUMP) begin
			if (out_free) begin
				rsp_q.status  <= ST_OK;
				rsp_q.element <= out_value(rd_data);
				rsp_q.last    <= dump_last;
			end
		end else if (accept) begin
			rsp_q.element <= '0;
			rsp_q.last    <= 1'b1;
			if (ins) begin
				if (full) begin
					rsp_q.status <= ST_FULL;
				end else if (!in_rng_ins) begin
					rsp_q.status <= ST_RANGE;
				end else begin
					rsp_q.status <= ST_OK;
				end
			end else if (del) begin
				if (empty) begin
					rsp_q.status <= ST_EMPTY;
				end else if (!in_rng_del) begin
					rsp_q.status <= ST_RANGE;
				end else begin
					rsp_q.status  <= ST_OK;
					rsp_q.element <= out_value(rd_data);
				end
			end else begin
				rsp_q.status <= ST_EMPTY;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/ordered_list_store_unit.sv -----
// Bounded ordered list of CAPACITY signed elements held in a row of cells,
// one element per cell with the front in cell zero. Inserts and deletes at
// the front, the back or a 1-based position shift the row, and each such
// request, as well as every error, returns one word in the cycle after it is
// taken. A dump of n elements streams n words, one per cycle while the output
// is not stalled, from the output register, the first loaded once the
// controller is in its dump state; no request is taken until the final word
// of a dump has been loaded. A request is taken only while the output
// register is empty or its word leaves in the same cycle, so a stalled word
// also stalls the input. Cells come out of reset undefined and need no
// clearing; only the control state, element count, dump index, dump direction and valid flag are reset.
module ordered_list_store_unit
	import ols_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_part [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.rd_data   (rd_data),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left, right;
		if (i == 0) begin : g_first
			assign left = ctl.data;
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = cell_q[i];
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end
		ols_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(i)),
			.ctl     (ctl),
			.left    (left),
			.right   (right),
			.q       (cell_q[i]),
			.rd_part (rd_part[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | rd_part[i];
		end
	end

endmodule

// ----- rtl/ols_checker.sv -----
module ols_checker
	import ols_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response word blocked");

	a_burst_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("request taken in the middle of a dump");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element == '0)
		else $error("error word not a single zero word");

endmodule

bind ordered_list_store_unit ols_checker u_ols_checker (.*);
